@@ hw/rtl/sme_pkg.sv @@
// Package for the stack machine execute unit: sizes, opcodes and the
// command/status structs shared by controller and datapath. No dependencies.
package sme_pkg;

  localparam int STACK_DEPTH  = 1024;
  localparam int GLOBAL_DEPTH = 256;
  localparam int STACK_AW     = $clog2(STACK_DEPTH);
  localparam int GLOBAL_AW    = $clog2(GLOBAL_DEPTH);
  localparam int PTR_W        = 11;
  localparam int PC_W         = 16;
  localparam int GC_W         = 9;

  typedef enum logic [7:0] {
    OP_HALT  = 8'd0,
    OP_PUSHC = 8'd1,
    OP_ADD   = 8'd2,
    OP_SUB   = 8'd3,
    OP_MUL   = 8'd4,
    OP_DIV   = 8'd5,
    OP_MOD   = 8'd6,
    OP_RDINT = 8'd7,
    OP_WRINT = 8'd8,
    OP_RDCHR = 8'd9,
    OP_WRCHR = 8'd10,
    OP_PUSHG = 8'd11,
    OP_POPG  = 8'd12,
    OP_ASF   = 8'd13,
    OP_RSF   = 8'd14,
    OP_PUSHL = 8'd15,
    OP_POPL  = 8'd16
  } op_t;

  typedef enum logic [2:0] {
    FLT_NONE      = 3'd0,
    FLT_OVERFLOW  = 3'd1,
    FLT_UNDERFLOW = 3'd2,
    FLT_DIV_ZERO  = 3'd3,
    FLT_GLOBAL    = 3'd4
  } fault_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic rd1;
    logic rd2;
    logic exec;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_div;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

@@ hw/rtl/sme_if.sv @@
// Handshake interfaces for the instruction, result and configuration channels.
// Depends on sme_pkg.
interface sme_in_if import sme_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic signed [31:0] read_value;
  modport source (output valid, instruction, read_value, input ready);
  modport sink (input valid, instruction, read_value, output ready);
endinterface

interface sme_out_if import sme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              write_valid;
  logic              write_is_char;
  logic signed [31:0] write_value;
  logic              halted;
  logic [2:0]        fault;
  logic [PTR_W-1:0]  stack_top_index;
  logic [PTR_W-1:0]  frame_index;
  logic [PC_W-1:0]   program_counter;
  modport source (output valid, write_valid, write_is_char, write_value, halted, fault,
                  stack_top_index, frame_index, program_counter, input ready);
  modport sink (input valid, write_valid, write_is_char, write_value, halted, fault,
                stack_top_index, frame_index, program_counter, output ready);
endinterface

interface sme_cfg_if import sme_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [GC_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/sme_divider.sv @@
// Signed 32-bit radix-2 restoring divider, one quotient bit per cycle.
// Depends on sme_pkg only for style consistency.
module sme_divider import sme_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r, quo_r, dvs_r;
  logic        neg_q_r, neg_r_r, done_r;
  logic [32:0] trial;

  assign trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        rem_r   <= '0;
        quo_r   <= dividend[31] ? (~dividend + 32'd1) : dividend;
        dvs_r   <= divisor[31] ? (~divisor + 32'd1) : divisor;
        neg_q_r <= dividend[31] ^ divisor[31];
        neg_r_r <= dividend[31];
      end else if (busy_r) begin
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= {rem_r[30:0], quo_r[31]};
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = neg_q_r ? (~quo_r + 32'd1) : quo_r;
  assign remainder = neg_r_r ? (~rem_r + 32'd1) : rem_r;

endmodule

@@ hw/rtl/sme_datapath.sv @@
// Datapath: stack and global memories, pointers, operand registers, fault
// checks, divider and the result register. Depends on sme_pkg, sme_divider.
module sme_datapath import sme_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [31:0] instruction,
  input  logic [31:0] read_value,
  input  logic        cfg_we,
  input  logic [GC_W-1:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_valid,
  output logic        out_write_is_char,
  output logic [31:0] out_write_value,
  output logic        out_halted,
  output logic [2:0]  out_fault,
  output logic [PTR_W-1:0] out_sp,
  output logic [PTR_W-1:0] out_fp,
  output logic [PC_W-1:0]  out_pc
);

  localparam int XW = 27;

  logic [31:0] stk_mem [STACK_DEPTH];
  logic [31:0] glb_mem [GLOBAL_DEPTH];
  logic [31:0] stk_q, glb_q;

  logic [STACK_AW-1:0] clr_r;
  logic [31:0] ins_r, rv_r, x_r, res_r;
  logic [PTR_W-1:0] sp_r, fp_r, sp_nxt, fp_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic        halt_r, halt_nxt;
  logic [GC_W-1:0] gc_r;
  fault_t      fault_r, fault_c;

  logic        out_valid_r, wv_r, wc_r, out_halt_r;
  logic [31:0] wval_r;
  logic [2:0]  out_fault_r;
  logic [PTR_W-1:0] out_sp_r, out_fp_r;
  logic [PC_W-1:0]  out_pc_r;

  op_t op;
  logic [31:0] imm32;
  logic signed [XW-1:0] imm_x, sp_x, fp_x, idx_x, asf_x, gb_x;
  logic [GC_W-1:0] gbound;
  logic [STACK_AW-1:0] addr1, rd_addr, wr_addr;
  logic [31:0] wr_data;
  logic        stk_we, glb_we, wv_c, wc_c;
  logic [31:0] wval_c;
  logic        div_done;
  logic [31:0] div_q, div_r;
  logic        out_free;

  assign op     = op_t'(ins_r[31:24]);
  assign imm32  = {{8{ins_r[23]}}, ins_r[23:0]};
  assign imm_x  = XW'(signed'(ins_r[23:0]));
  assign sp_x   = signed'(XW'(sp_r));
  assign fp_x   = signed'(XW'(fp_r));
  assign idx_x  = fp_x + imm_x;
  assign asf_x  = sp_x + XW'(1) + imm_x;
  assign gbound = (gc_r < GC_W'(GLOBAL_DEPTH)) ? gc_r : GC_W'(GLOBAL_DEPTH);
  assign gb_x   = signed'(XW'(gbound));
  assign out_free = !out_valid_r || out_ready;

  // first and second read addresses
  always_comb begin
    case (op)
      OP_RSF:   addr1 = STACK_AW'(fp_r - PTR_W'(1));
      OP_PUSHL: addr1 = idx_x[STACK_AW-1:0];
      default:  addr1 = STACK_AW'(sp_r - PTR_W'(1));
    endcase
    rd_addr = cmd_i.rd1 ? addr1 : STACK_AW'(sp_r - PTR_W'(2));
  end

  // fault checks, evaluated in the execute step
  always_comb begin
    fault_c = FLT_NONE;
    if (!halt_r) begin
      case (op)
        OP_PUSHC, OP_RDINT, OP_RDCHR:
          if (sp_r >= PTR_W'(STACK_DEPTH)) fault_c = FLT_OVERFLOW;
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
          if (sp_r < PTR_W'(2)) fault_c = FLT_UNDERFLOW;
          else if ((op == OP_DIV || op == OP_MOD) && x_r == 32'd0) fault_c = FLT_DIV_ZERO;
        OP_WRINT, OP_WRCHR:
          if (sp_r == '0) fault_c = FLT_UNDERFLOW;
        OP_PUSHG:
          if (imm_x < 0 || imm_x >= gb_x) fault_c = FLT_GLOBAL;
          else if (sp_r >= PTR_W'(STACK_DEPTH)) fault_c = FLT_OVERFLOW;
        OP_POPG:
          if (imm_x < 0 || imm_x >= gb_x) fault_c = FLT_GLOBAL;
          else if (sp_r == '0) fault_c = FLT_UNDERFLOW;
        OP_ASF:
          if (imm_x < 0) fault_c = FLT_UNDERFLOW;
          else if (asf_x > XW'(STACK_DEPTH)) fault_c = FLT_OVERFLOW;
        OP_RSF:
          if (fp_r == '0) fault_c = FLT_UNDERFLOW;
          else if (x_r[31]) fault_c = FLT_UNDERFLOW;
          else if (x_r > 32'(STACK_DEPTH)) fault_c = FLT_OVERFLOW;
        OP_PUSHL:
          if (idx_x < 0) fault_c = FLT_UNDERFLOW;
          else if (idx_x >= XW'(STACK_DEPTH)) fault_c = FLT_OVERFLOW;
          else if (sp_r >= PTR_W'(STACK_DEPTH)) fault_c = FLT_OVERFLOW;
        OP_POPL:
          if (idx_x < 0) fault_c = FLT_UNDERFLOW;
          else if (idx_x >= XW'(STACK_DEPTH)) fault_c = FLT_OVERFLOW;
          else if (sp_r == '0) fault_c = FLT_UNDERFLOW;
        default: fault_c = FLT_NONE;
      endcase
    end
  end

  // state update applied at commit
  always_comb begin
    sp_nxt = sp_r; fp_nxt = fp_r; halt_nxt = halt_r;
    pc_nxt = pc_r + PC_W'(1);
    stk_we = 1'b0; glb_we = 1'b0;
    wr_addr = STACK_AW'(sp_r); wr_data = x_r;
    wv_c = 1'b0; wc_c = 1'b0; wval_c = '0;
    case (op)
      OP_HALT: begin
        halt_nxt = 1'b1; pc_nxt = pc_r;
      end
      OP_PUSHC, OP_RDINT, OP_RDCHR: begin
        stk_we = 1'b1;
        wr_data = (op == OP_PUSHC) ? imm32 : ((op == OP_RDINT) ? rv_r : {24'd0, rv_r[7:0]});
        sp_nxt = sp_r + PTR_W'(1);
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        stk_we = 1'b1; wr_addr = STACK_AW'(sp_r - PTR_W'(2)); wr_data = res_r;
        sp_nxt = sp_r - PTR_W'(1);
      end
      OP_WRINT, OP_WRCHR: begin
        sp_nxt = sp_r - PTR_W'(1);
        wv_c = 1'b1; wc_c = (op == OP_WRCHR); wval_c = x_r;
      end
      OP_PUSHG, OP_PUSHL: begin
        stk_we = 1'b1; sp_nxt = sp_r + PTR_W'(1);
      end
      OP_POPG: begin
        glb_we = 1'b1; sp_nxt = sp_r - PTR_W'(1);
      end
      OP_ASF: begin
        stk_we = 1'b1; wr_data = 32'(fp_r);
        fp_nxt = sp_r + PTR_W'(1);
        sp_nxt = asf_x[PTR_W-1:0];
      end
      OP_RSF: begin
        sp_nxt = fp_r - PTR_W'(1);
        fp_nxt = x_r[PTR_W-1:0];
      end
      OP_POPL: begin
        stk_we = 1'b1; wr_addr = idx_x[STACK_AW-1:0];
        sp_nxt = sp_r - PTR_W'(1);
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd_i.clear) begin
      stk_mem[clr_r] <= '0;
      if (clr_r < STACK_AW'(GLOBAL_DEPTH)) glb_mem[clr_r[GLOBAL_AW-1:0]] <= '0;
    end else if (cmd_i.commit && !halt_r && fault_r == FLT_NONE) begin
      if (stk_we) stk_mem[wr_addr] <= wr_data;
      if (glb_we) glb_mem[imm32[GLOBAL_AW-1:0]] <= x_r;
    end
    if (cmd_i.rd1 || cmd_i.rd2) stk_q <= stk_mem[rd_addr];
    if (cmd_i.rd1) glb_q <= glb_mem[imm32[GLOBAL_AW-1:0]];
  end

  sme_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd_i.exec && stat_o.need_div),
    .dividend  (stk_q),
    .divisor   (x_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // operands and results
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      ins_r <= instruction;
      rv_r  <= read_value;
    end
    if (cmd_i.rd2) x_r <= (op == OP_PUSHG) ? glb_q : stk_q;
    if (cmd_i.exec) begin
      case (op)
        OP_ADD:  res_r <= stk_q + x_r;
        OP_SUB:  res_r <= stk_q - x_r;
        OP_MUL:  res_r <= stk_q * x_r;
        default: res_r <= stk_q;
      endcase
    end else if (div_done) begin
      res_r <= (op == OP_DIV) ? div_q : div_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0; sp_r <= '0; fp_r <= '0; pc_r <= '0; halt_r <= 1'b0;
      gc_r <= GC_W'(256); fault_r <= FLT_NONE; out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) gc_r <= cfg_data;
      if (cmd_i.clear) clr_r <= clr_r + STACK_AW'(1);
      if (cmd_i.exec) fault_r <= fault_c;
      if (out_ready) out_valid_r <= 1'b0;
      if (cmd_i.commit) begin
        out_valid_r <= 1'b1;
        wv_r <= 1'b0; wc_r <= 1'b0; wval_r <= '0;
        out_halt_r <= halt_r; out_fault_r <= fault_r;
        out_sp_r <= sp_r; out_fp_r <= fp_r; out_pc_r <= pc_r;
        if (!halt_r && fault_r == FLT_NONE) begin
          sp_r <= sp_nxt; fp_r <= fp_nxt; pc_r <= pc_nxt; halt_r <= halt_nxt;
          wv_r <= wv_c; wc_r <= wc_c; wval_r <= wval_c;
          out_halt_r <= halt_nxt;
          out_sp_r <= sp_nxt; out_fp_r <= fp_nxt; out_pc_r <= pc_nxt;
        end
      end
    end
  end

  assign stat_o.clear_last = (clr_r == STACK_AW'(STACK_DEPTH - 1));
  assign stat_o.need_div   = (op == OP_DIV || op == OP_MOD) && fault_c == FLT_NONE && !halt_r;
  assign stat_o.div_done   = div_done;
  assign stat_o.out_free   = out_free;

  assign out_valid         = out_valid_r;
  assign out_write_valid   = wv_r;
  assign out_write_is_char = wc_r;
  assign out_write_value   = wval_r;
  assign out_halted        = out_halt_r;
  assign out_fault         = out_fault_r;
  assign out_sp            = out_sp_r;
  assign out_fp            = out_fp_r;
  assign out_pc            = out_pc_r;

  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.commit |-> out_free) else $error("commit with result slot occupied");
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PTR_W'(STACK_DEPTH)) else $error("stack pointer out of range");
  a_fp_range: assert property (@(posedge clk) disable iff (!rst_n)
    fp_r <= PTR_W'(STACK_DEPTH)) else $error("frame pointer out of range");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt flag cleared");

endmodule

@@ hw/rtl/sme_ctrl.sv @@
// Controller: sequences clear pass, operand reads, execute, divide and commit.
// Depends on sme_pkg.
module sme_ctrl import sme_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_COMMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o = '0;
    case (state_r)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.load = in_valid;
        if (in_valid) state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd1 = 1'b1; state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd_o.rd2 = 1'b1; state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_nxt = stat_i.need_div ? S_DIV : S_COMMIT;
      end
      S_DIV: begin
        if (stat_i.div_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = stat_i.out_free;
        if (stat_i.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

@@ hw/rtl/stack_machine_executor_core.sv @@
// Top level of the stack machine execute unit: controller plus datapath.
// Depends on sme_pkg, sme_if, sme_ctrl, sme_datapath, sme_divider.
//
//  channel  | dir | carries                                   | handshake
//  in_ch    | in  | instruction, read_value                   | valid/ready
//  out_ch   | out | write_*, halted, fault, sp, fp, pc        | valid/ready
//  cfg_ch   | in  | global_count (9 bits)                     | valid/ready
//
// After reset the stack and global memories are zeroed, one entry per cycle,
// with in_ready low; configuration writes are taken meanwhile.
// An item passes through load, two stack reads through the single memory
// port, execute and commit; div and mod add a pass through the bit-serial divider.
// One item is in flight at a time; the result register lets the next item
// enter while a result waits, and commit stalls only while that register is full.
module stack_machine_executor_core import sme_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  sme_in_if.sink    in_ch,
  sme_out_if.source out_ch,
  sme_cfg_if.sink   cfg_ch
);

  cmd_t  cmd;
  stat_t stat;

  // the register is always writable
  assign cfg_ch.ready = 1'b1;

  sme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  sme_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .instruction       (in_ch.instruction),
    .read_value        (in_ch.read_value),
    .cfg_we            (cfg_ch.valid),
    .cfg_data          (cfg_ch.data),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_write_valid   (out_ch.write_valid),
    .out_write_is_char (out_ch.write_is_char),
    .out_write_value   (out_ch.write_value),
    .out_halted        (out_ch.halted),
    .out_fault         (out_ch.fault),
    .out_sp            (out_ch.stack_top_index),
    .out_fp            (out_ch.frame_index),
    .out_pc            (out_ch.program_counter)
  );

endmodule
